@@ design/matrix_scan_debouncer_macros.svh @@
// Assertion helpers for the matrix scan debouncer.
// Both macros expect signals named clock and reset in the enclosing scope.
`ifndef MATRIX_SCAN_DEBOUNCER_MACROS_SVH
`define MATRIX_SCAN_DEBOUNCER_MACROS_SVH

// Same-cycle implication
`define MSD_ASSERT_IMPL(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("matrix_scan_debouncer: same-cycle check failed");

// Next-cycle implication
`define MSD_ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("matrix_scan_debouncer: next-cycle check failed");

`endif

@@ design/msd_pkg.sv @@
package msd_pkg;

   // Default matrix geometry
   localparam int NUM_ROWS_DEFAULT    = 4;
   localparam int NUM_COLUMNS_DEFAULT = 6;

   // Fixed field widths
   localparam int LEVELS_W   = 6;
   localparam int COUNT_W    = 8;
   localparam int ROW_OUT_W  = 2;
   localparam int CODE_OUT_W = 3;
   localparam int STABLE_OUTS = 4;

   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd4;

   // Per-row debounce phase
   typedef enum logic [2:0] {
      PH_WAIT    = 3'b001,
      PH_CHECK   = 3'b010,
      PH_SETTLED = 3'b100
   } phase_type;

endpackage

@@ design/matrix_scan_debouncer.sv @@
// A request accepted into the input register moves on to the result register, where the
// debounce update is applied, only when the result register is free or being drained.
// One request per cycle while responses are taken, set by the single-pass row update
// between registers; a stalled result register holds the input stage.
// Reset (synchronous, active high): row 0, every row waiting with zero code and count,
// debounce count 4, both pipeline stages empty.
module matrix_scan_debouncer #(
   parameter int NUM_ROWS    = msd_pkg::NUM_ROWS_DEFAULT,
   parameter int NUM_COLUMNS = msd_pkg::NUM_COLUMNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [msd_pkg::LEVELS_W-1:0]      req_column_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [msd_pkg::ROW_OUT_W-1:0]     rsp_scanned_row,
   output logic [msd_pkg::ROW_OUT_W-1:0]     rsp_next_row,
   output logic [msd_pkg::CODE_OUT_W-1:0]    rsp_raw_code,
   output logic                              rsp_published,
   output logic [msd_pkg::CODE_OUT_W-1:0]    rsp_stable_row0,
   output logic [msd_pkg::CODE_OUT_W-1:0]    rsp_stable_row1,
   output logic [msd_pkg::CODE_OUT_W-1:0]    rsp_stable_row2,
   output logic [msd_pkg::CODE_OUT_W-1:0]    rsp_stable_row3,
   input  logic                              csr_wr_en,
   input  logic [msd_pkg::COUNT_W-1:0]       csr_wr_data
);

`include "matrix_scan_debouncer_macros.svh"

   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int ROW_EXT  = (ROW_W > msd_pkg::ROW_OUT_W) ? ROW_W : msd_pkg::ROW_OUT_W;
   localparam int CODE_W   = $clog2(NUM_COLUMNS + 1);
   localparam int CODE_EXT = (CODE_W > msd_pkg::CODE_OUT_W) ? CODE_W : msd_pkg::CODE_OUT_W;
   localparam int LEV_EXT  = (NUM_COLUMNS > msd_pkg::LEVELS_W) ? NUM_COLUMNS
                                                               : msd_pkg::LEVELS_W;

   logic [msd_pkg::COUNT_W-1:0]  debounce_ff, debounce_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [msd_pkg::LEVELS_W-1:0] s1_levels_ff, s1_levels_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [msd_pkg::ROW_OUT_W-1:0]  scanned_ff, scanned_in;
   logic [msd_pkg::ROW_OUT_W-1:0]  next_ff, next_in;
   logic [msd_pkg::CODE_OUT_W-1:0] raw_ff, raw_in;
   logic                           pub_ff, pub_in;

   logic                     advance;
   logic [LEV_EXT-1:0]       levels_ext;
   logic [CODE_W-1:0]        code;
   logic [CODE_EXT-1:0]      code_ext;
   logic [ROW_W-1:0]         row_next;
   logic [ROW_EXT-1:0]       row_cur_ext, row_next_ext;
   logic [NUM_ROWS-1:0]      row_step;
   logic [NUM_ROWS-1:0]      row_pub;
   logic [CODE_W-1:0]        row_stable [NUM_ROWS];
   logic [msd_pkg::CODE_OUT_W-1:0] stable_out [msd_pkg::STABLE_OUTS];

   // Handshake: input stage moves on when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Configuration register
   assign debounce_in = csr_wr_en ? csr_wr_data : debounce_ff;

   // Input stage
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_levels_in = s1_levels_ff;
      if (req_valid && req_ready) begin
         s1_valid_in  = 1'b1;
         s1_levels_in = req_column_levels;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Priority encode the sampled row; columns beyond the input read as pressed lines low
   assign levels_ext = LEV_EXT'(s1_levels_ff);

   msd_encoder #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .CODE_W      (CODE_W)
   ) u_encoder (
      .levels (levels_ext[NUM_COLUMNS-1:0]),
      .code   (code)
   );

   // Row scan counter
   assign row_next = (row_ff == ROW_W'(NUM_ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign row_in   = advance ? row_next : row_ff;

   // Per-row debounce machines
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      assign row_step[r] = advance && (row_ff == ROW_W'(r));

      msd_row_fsm #(
         .CODE_W (CODE_W)
      ) u_row (
         .clock       (clock),
         .reset       (reset),
         .step        (row_step[r]),
         .code        (code),
         .debounce    (debounce_ff),
         .stable_code (row_stable[r]),
         .publish     (row_pub[r])
      );
   end

   // Result register
   assign row_cur_ext  = ROW_EXT'(row_ff);
   assign row_next_ext = ROW_EXT'(row_next);
   assign code_ext     = CODE_EXT'(code);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      scanned_in   = scanned_ff;
      next_in      = next_ff;
      raw_in       = raw_ff;
      pub_in       = pub_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         scanned_in   = row_cur_ext[msd_pkg::ROW_OUT_W-1:0];
         next_in      = row_next_ext[msd_pkg::ROW_OUT_W-1:0];
         raw_in       = code_ext[msd_pkg::CODE_OUT_W-1:0];
         pub_in       = |row_pub;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= msd_pkg::DEBOUNCE_RESET;
         s1_valid_ff  <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         s1_valid_ff  <= s1_valid_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_levels_ff <= s1_levels_in;
      scanned_ff   <= scanned_in;
      next_ff      <= next_in;
      raw_ff       <= raw_in;
      pub_ff       <= pub_in;
   end

   // Stable codes only change on the edge that loads the result register
   for (genvar k = 0; k < msd_pkg::STABLE_OUTS; k++) begin : g_stable
      if (k < NUM_ROWS) begin : g_used
         logic [CODE_EXT-1:0] wide;
         assign wide          = CODE_EXT'(row_stable[k]);
         assign stable_out[k] = wide[msd_pkg::CODE_OUT_W-1:0];
      end else begin : g_unused
         assign stable_out[k] = '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scanned_row = scanned_ff;
   assign rsp_next_row    = next_ff;
   assign rsp_raw_code    = raw_ff;
   assign rsp_published   = pub_ff;
   assign rsp_stable_row0 = stable_out[0];
   assign rsp_stable_row1 = stable_out[1];
   assign rsp_stable_row2 = stable_out[2];
   assign rsp_stable_row3 = stable_out[3];

   // Checks
   `MSD_ASSERT_IMPL(a_one_row_steps, 1'b1, $onehot0(row_step))
   `MSD_ASSERT_NEXT(a_row_holds, !advance, $stable(row_ff))
   `MSD_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_levels_ff))
   `MSD_ASSERT_NEXT(a_pub_stable, advance && (|row_pub),
      rsp_valid && rsp_published && (stable_out[0] == rsp_raw_code ||
      stable_out[1] == rsp_raw_code || stable_out[2] == rsp_raw_code ||
      stable_out[3] == rsp_raw_code))

endmodule

@@ design/msd_encoder.sv @@
module msd_encoder #(
   parameter int NUM_COLUMNS = msd_pkg::NUM_COLUMNS_DEFAULT,
   parameter int CODE_W      = $clog2(NUM_COLUMNS + 1)
) (
   input  logic [NUM_COLUMNS-1:0] levels,
   output logic [CODE_W-1:0]      code
);

   // Lowest pressed (low) column wins; zero means nothing pressed
   always_comb begin
      code = '0;
      for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
         if (!levels[c]) begin
            code = CODE_W'(c + 1);
         end
      end
   end

endmodule

@@ design/msd_row_fsm.sv @@
module msd_row_fsm #(
   parameter int CODE_W = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [CODE_W-1:0]            code,
   input  logic [msd_pkg::COUNT_W-1:0]  debounce,
   output logic [CODE_W-1:0]            stable_code,
   output logic                         publish
);

   msd_pkg::phase_type             phase_ff, phase_in;
   logic [CODE_W-1:0]              last_ff, last_in;
   logic [msd_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [CODE_W-1:0]              stable_ff, stable_in;
   logic [msd_pkg::COUNT_W-1:0]    count_dec;
   logic                           same;

   assign same      = (code == last_ff);
   assign count_dec = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   // Debounce machine, advanced only when this row is sampled
   always_comb begin
      phase_in  = phase_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      stable_in = stable_ff;
      publish   = 1'b0;
      if (step) begin
         unique case (phase_ff)
            msd_pkg::PH_WAIT: begin
               last_in  = code;
               count_in = debounce;
               phase_in = msd_pkg::PH_CHECK;
            end
            msd_pkg::PH_CHECK: begin
               if (!same) begin
                  last_in  = code;
                  phase_in = msd_pkg::PH_WAIT;
               end else begin
                  count_in = count_dec;
                  if (count_dec == '0) begin
                     stable_in = code;
                     publish   = 1'b1;
                     phase_in  = msd_pkg::PH_SETTLED;
                  end
               end
            end
            msd_pkg::PH_SETTLED: begin
               if (!same) begin
                  last_in  = code;
                  phase_in = msd_pkg::PH_WAIT;
               end
            end
            default: begin
               phase_in = msd_pkg::PH_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= msd_pkg::PH_WAIT;
         last_ff   <= '0;
         count_ff  <= '0;
         stable_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         stable_ff <= stable_in;
      end
   end

   assign stable_code = stable_ff;

endmodule

@@ sim/matrix_scan_debouncer_test.sv @@
module matrix_scan_debouncer_test;

   localparam int ROWS = msd_pkg::NUM_ROWS_DEFAULT;
   localparam int COLUMNS = msd_pkg::NUM_COLUMNS_DEFAULT;
   localparam int LEVELS_W = msd_pkg::LEVELS_W;
   localparam int COUNT_W = msd_pkg::COUNT_W;
   localparam int ROW_OUT_W = msd_pkg::ROW_OUT_W;
   localparam int CODE_OUT_W = msd_pkg::CODE_OUT_W;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [ROW_OUT_W-1:0]  scanned_row;
      logic [ROW_OUT_W-1:0]  next_row;
      logic [CODE_OUT_W-1:0] raw_code;
      logic                  published;
      logic [CODE_OUT_W-1:0] stable_row0;
      logic [CODE_OUT_W-1:0] stable_row1;
      logic [CODE_OUT_W-1:0] stable_row2;
      logic [CODE_OUT_W-1:0] stable_row3;
   } scan_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [LEVELS_W-1:0]   req_column_levels = '1;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ROW_OUT_W-1:0]  rsp_scanned_row;
   logic [ROW_OUT_W-1:0]  rsp_next_row;
   logic [CODE_OUT_W-1:0] rsp_raw_code;
   logic                  rsp_published;
   logic [CODE_OUT_W-1:0] rsp_stable_row0;
   logic [CODE_OUT_W-1:0] rsp_stable_row1;
   logic [CODE_OUT_W-1:0] rsp_stable_row2;
   logic [CODE_OUT_W-1:0] rsp_stable_row3;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   // Debouncer state as the scanner should hold it
   logic [COUNT_W-1:0]    debounce_q;
   int unsigned           scan_row;
   logic [CODE_OUT_W-1:0] last_code_q [ROWS];
   logic [COUNT_W-1:0]    countdown_q [ROWS];
   msd_pkg::phase_type    row_phase_q [ROWS];
   logic [CODE_OUT_W-1:0] stable_q [ROWS];

   scan_result_type       expected_scans [$];
   logic [CODE_OUT_W-1:0] held_code [ROWS];
   int unsigned           mismatch_count = 0;
   bit                    idling_on = 1'b1;
   bit                    hold_go = 1'b0;
   bit                    hold_off = 1'b0;
   int unsigned           stall_left = 0;

   matrix_scan_debouncer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_column_levels (req_column_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scanned_row   (rsp_scanned_row),
      .rsp_next_row      (rsp_next_row),
      .rsp_raw_code      (rsp_raw_code),
      .rsp_published     (rsp_published),
      .rsp_stable_row0   (rsp_stable_row0),
      .rsp_stable_row1   (rsp_stable_row1),
      .rsp_stable_row2   (rsp_stable_row2),
      .rsp_stable_row3   (rsp_stable_row3),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #(12 * 300000);
      $display("matrix_scan_debouncer_test: FAIL");
      $finish;
   end

   // Lowest pressed column wins; all lines high means no key
   function automatic logic [CODE_OUT_W-1:0] column_code(input logic [LEVELS_W-1:0] levels);
      int i;
      for (i = 0; i < COLUMNS; i++) begin
         if (!levels[i]) return CODE_OUT_W'(i + 1);
      end
      return '0;
   endfunction

   // Build random column levels that encode the given code
   function automatic logic [LEVELS_W-1:0] levels_for(input logic [CODE_OUT_W-1:0] code);
      logic [LEVELS_W-1:0] levels;
      int c;
      int i;
      levels = LEVELS_W'($urandom);
      c = int'(code);
      if (c == 0) return '1;
      for (i = 0; i < c - 1; i++) levels[i] = 1'b1;
      levels[c-1] = 1'b0;
      return levels;
   endfunction

   // Advance the per-row debounce machine and queue the expected response
   task automatic predict_scan(input logic [LEVELS_W-1:0] levels);
      scan_result_type want;
      int unsigned row;
      logic [CODE_OUT_W-1:0] code;
      bit pub;
      row = scan_row;
      code = column_code(levels);
      pub = 1'b0;
      case (row_phase_q[row])
         msd_pkg::PH_WAIT: begin
            last_code_q[row] = code;
            countdown_q[row] = debounce_q;
            row_phase_q[row] = msd_pkg::PH_CHECK;
         end
         msd_pkg::PH_CHECK: begin
            if (code != last_code_q[row]) begin
               last_code_q[row] = code;
               row_phase_q[row] = msd_pkg::PH_WAIT;
            end else begin
               if (countdown_q[row] != 0) countdown_q[row] = countdown_q[row] - 1'b1;
               if (countdown_q[row] == 0) begin
                  stable_q[row] = code;
                  pub = 1'b1;
                  row_phase_q[row] = msd_pkg::PH_SETTLED;
               end
            end
         end
         msd_pkg::PH_SETTLED: begin
            if (code != last_code_q[row]) begin
               last_code_q[row] = code;
               row_phase_q[row] = msd_pkg::PH_WAIT;
            end
         end
         default: row_phase_q[row] = msd_pkg::PH_WAIT;
      endcase
      scan_row = (row + 1) % ROWS;
      want.scanned_row = ROW_OUT_W'(row);
      want.next_row    = ROW_OUT_W'(scan_row);
      want.raw_code    = code;
      want.published   = pub;
      want.stable_row0 = stable_q[0];
      want.stable_row1 = stable_q[1];
      want.stable_row2 = stable_q[2];
      want.stable_row3 = stable_q[3];
      expected_scans.push_back(want);
   endtask

   // Offer one request, with an occasional idle burst first, and hold it until taken
   task automatic offer_levels(input logic [LEVELS_W-1:0] levels);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_column_levels <= levels;
      do @(posedge clock); while (!req_ready);
      predict_scan(levels);
   endtask

   // Drain the pipeline, then load a new debounce count
   task automatic write_debounce(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      debounce_q = value;
   endtask

   // Mostly held codes per row with random don't-care bits, some bounces and noise
   task automatic scan_items(input int count, input int change_pct, input int noise_pct);
      int k;
      int unsigned r;
      for (k = 0; k < count; k++) begin
         r = scan_row;
         if ($urandom_range(0, 99) < noise_pct) begin
            offer_levels(LEVELS_W'($urandom));
         end else begin
            if ($urandom_range(0, 99) < change_pct)
               held_code[r] = CODE_OUT_W'($urandom_range(0, COLUMNS));
            offer_levels(levels_for(held_code[r]));
         end
      end
   endtask

   // Every code once, plus all lines high and all lines low
   task automatic test_column_codes();
      offer_levels(6'h3F);
      offer_levels(6'h00);
      offer_levels(6'h3D);
      offer_levels(6'h3B);
      offer_levels(6'h37);
      offer_levels(6'h2F);
      offer_levels(6'h1F);
      offer_levels(6'h2A);
   endtask

   // With a zero count the first equal checking sample publishes
   task automatic test_zero_count();
      int k;
      write_debounce('0);
      for (k = 0; k < 2 * ROWS; k++) offer_levels(levels_for(CODE_OUT_W'(scan_row + 1)));
   endtask

   // Release and press the same key again: the same code publishes a second time
   task automatic test_republish();
      int k;
      for (k = 0; k < ROWS; k++) offer_levels(6'h3F);
      for (k = 0; k < 2 * ROWS; k++) offer_levels(levels_for(CODE_OUT_W'(scan_row + 1)));
   endtask

   task automatic test_count_sweep();
      write_debounce(8'd1);
      scan_items(90, 15, 5);
      write_debounce(8'd3);
      scan_items(90, 8, 5);
      write_debounce('0);
      scan_items(80, 25, 10);
      write_debounce(COUNT_W'($urandom_range(2, 12)));
      scan_items(110, 4, 3);
   endtask

   // Hold off the response side long enough for the input to stall
   task automatic test_backpressure();
      write_debounce(8'd2);
      hold_go = 1'b1;
      scan_items(30, 5, 0);
   endtask

   // Largest count, no idling: each row must see 256 equal samples
   task automatic test_long_count();
      idling_on <= 1'b0;
      write_debounce('1);
      scan_items(1040, 0, 0);
   endtask

   // Long response hold-off, counted here
   initial begin
      forever begin
         wait (hold_go);
         hold_off <= 1'b1;
         repeat (80) @(posedge clock);
         hold_off <= 1'b0;
         hold_go = 1'b0;
      end
   end

   // Drive response ready with random stall bursts
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each response with the oldest expected one
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: row %0d raw %0d pub %0d",
                        rsp_scanned_row, rsp_raw_code, rsp_published);
         end else begin
            want = expected_scans.pop_front();
            if (rsp_scanned_row !== want.scanned_row || rsp_next_row !== want.next_row ||
                rsp_raw_code !== want.raw_code || rsp_published !== want.published ||
                rsp_stable_row0 !== want.stable_row0 || rsp_stable_row1 !== want.stable_row1 ||
                rsp_stable_row2 !== want.stable_row2 || rsp_stable_row3 !== want.stable_row3)
            begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display({"mismatch expected: row %0d next %0d raw %0d pub %0d",
                            " stable %0d %0d %0d %0d"},
                           want.scanned_row, want.next_row, want.raw_code, want.published,
                           want.stable_row0, want.stable_row1, want.stable_row2,
                           want.stable_row3);
                  $display({"         actual:   row %0d next %0d raw %0d pub %0d",
                            " stable %0d %0d %0d %0d"},
                           rsp_scanned_row, rsp_next_row, rsp_raw_code, rsp_published,
                           rsp_stable_row0, rsp_stable_row1, rsp_stable_row2, rsp_stable_row3);
               end
            end
         end
      end
   end

   initial begin
      int r;
      debounce_q = msd_pkg::DEBOUNCE_RESET;
      scan_row = 0;
      for (r = 0; r < ROWS; r++) begin
         last_code_q[r] = '0;
         countdown_q[r] = '0;
         row_phase_q[r] = msd_pkg::PH_WAIT;
         stable_q[r] = '0;
         held_code[r] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_column_codes();
      test_zero_count();
      test_republish();
      test_count_sweep();
      test_backpressure();
      test_long_count();

      // Drain and let the pipeline settle
      req_valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("matrix_scan_debouncer_test: PASS");
      end else begin
         $display("matrix_scan_debouncer_test: FAIL");
      end
      $finish;
   end

endmodule
